FILE: design/palette_mapped_tile_blitter_macros.svh
// ----------------------------------------------------------------------------
// palette_mapped_tile_blitter_macros
// assertion shorthands for the tile blitter checks
// ----------------------------------------------------------------------------
`ifndef PALETTE_MAPPED_TILE_BLITTER_MACROS_SVH
`define PALETTE_MAPPED_TILE_BLITTER_MACROS_SVH

// same-cycle implication
`define PMTB_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pmtb check failed");

// next-cycle implication
`define PMTB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pmtb check failed");

`endif

FILE: design/pmtb_pkg.sv
// ----------------------------------------------------------------------------
// pmtb_pkg
// item types and codes shared by the tile blitter modules
// ----------------------------------------------------------------------------
package pmtb_pkg;

  localparam int XY_W    = 12;
  localparam int COLOR_W = 32;

  // action codes
  localparam logic [1:0] ACT_PAL_WR = 2'd0;
  localparam logic [1:0] ACT_START  = 2'd1;
  localparam logic [1:0] ACT_DATA   = 2'd2;

  // pixel formats
  localparam logic [1:0] FMT_8OPQ = 2'd0;
  localparam logic [1:0] FMT_8TRN = 2'd1;
  localparam logic [1:0] FMT_4PK  = 2'd2;
  localparam logic [1:0] FMT_4SW  = 2'd3;

  typedef struct packed {
    logic [1:0]         action;
    logic [XY_W-1:0]    pos_x;
    logic [XY_W-1:0]    pos_y;
    logic [1:0]         size_code;
    logic [6:0]         row_count;
    logic [1:0]         format;
    logic               flip_rows;
    logic               flip_cols;
    logic [7:0]         index_value;
    logic [COLOR_W-1:0] table_value;
    logic [7:0]         data_byte;
  } in_item_t;

  typedef struct packed {
    logic [XY_W-1:0]    pix_x;
    logic [XY_W-1:0]    pix_y;
    logic [COLOR_W-1:0] color;
    logic               write_enable;
    logic               last_of_item;
    logic               tile_done;
  } out_item_t;

  // one pixel before its color is known
  typedef struct packed {
    logic [XY_W-1:0] pix_x;
    logic [XY_W-1:0] pix_y;
    logic            write_enable;
    logic            last_of_item;
    logic            tile_done;
  } pix_meta_t;

  // what one data byte turns into
  typedef struct packed {
    logic      two_pix;
    pix_meta_t p0;
    pix_meta_t p1;
  } byte_job_t;

endpackage

FILE: design/palette_mapped_tile_blitter.sv
// ----------------------------------------------------------------------------
// palette_mapped_tile_blitter
// a taken byte waits in the holding stage, each pixel then in the output register
// one pixel per 8-bit byte, two per packed 4-bit byte (one result port)
// palette writes and tile starts wait on the holding stage too, which sets the rate
// reset: counters idle, no tile active, palette contents undefined until written
// ----------------------------------------------------------------------------
module palette_mapped_tile_blitter import pmtb_pkg::*; #(
  parameter int PALETTE_DEPTH = 256,
  parameter int COLOR_BITS    = 32,
  parameter int MAX_TILE      = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  localparam int AW = $clog2(PALETTE_DEPTH);

  logic                  in_accept;
  logic                  seq_free;

  // palette port
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [COLOR_BITS-1:0] wr_data;
  logic [AW-1:0]         rd0_addr, rd1_addr;
  logic [COLOR_BITS-1:0] rd0_data, rd1_data;

  // per-byte pixel job
  logic                  job_load;
  byte_job_t             job;

  // any item waits while the holding stage cannot take a new byte;
  // the stage frees in the cycle its last pixel moves to the output register
  assign in_stall_o = !seq_free;
  assign in_accept  = in_valid_i && !in_stall_o;

  // tile state, counters, pixel position and pen addresses
  pmtb_walker #(
    .MAX_TILE     (MAX_TILE),
    .PALETTE_DEPTH(PALETTE_DEPTH),
    .COLOR_BITS   (COLOR_BITS),
    .AW           (AW)
  ) u_walker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (in_accept),
    .in_item_i (in_item_i),
    .wr_en_o   (wr_en),
    .wr_addr_o (wr_addr),
    .wr_data_o (wr_data),
    .job_load_o(job_load),
    .job_o     (job),
    .rd0_addr_o(rd0_addr),
    .rd1_addr_o(rd1_addr)
  );

  // palette lookups for both pens of a byte happen at the accept edge;
  // writes and reads come from different items so they never share an edge,
  // and a byte sees every palette write taken before it
  pmtb_palette_mem #(
    .DEPTH(PALETTE_DEPTH),
    .AW   (AW),
    .DW   (COLOR_BITS)
  ) u_palette (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (job_load),
    .rd0_addr_i(rd0_addr),
    .rd1_addr_i(rd1_addr),
    .rd0_data_o(rd0_data),
    .rd1_data_o(rd1_data)
  );

  // holding stage plus output register, one pixel per cycle out while the receiver does not stall
  pmtb_out_seq #(
    .COLOR_BITS(COLOR_BITS)
  ) u_out_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (job_load),
    .job_i      (job),
    .rd0_data_i (rd0_data),
    .rd1_data_i (rd1_data),
    .out_stall_i(out_stall_i),
    .free_o     (seq_free),
    .out_valid_o(out_valid_o),
    .out_item_o (out_item_o)
  );

endmodule

FILE: design/pmtb_palette_mem.sv
// ----------------------------------------------------------------------------
// pmtb_palette_mem
// palette store, one write port and two registered read ports
// ----------------------------------------------------------------------------
module pmtb_palette_mem #(
  parameter int DEPTH = 256,
  parameter int AW    = 8,
  parameter int DW    = 32
) (
  input  logic          clk_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [DW-1:0] wr_data_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd0_addr_i,
  input  logic [AW-1:0] rd1_addr_i,
  output logic [DW-1:0] rd0_data_o,
  output logic [DW-1:0] rd1_data_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd0_q;
  logic [DW-1:0] rd1_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // read data holds until the next read strobe
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd0_q <= mem[rd0_addr_i];
      rd1_q <= mem[rd1_addr_i];
    end
  end

  assign rd0_data_o = rd0_q;
  assign rd1_data_o = rd1_q;

endmodule

FILE: design/pmtb_walker.sv
// ----------------------------------------------------------------------------
// pmtb_walker
// tile setup registers, row and column counters, pixel placement and pens
// ----------------------------------------------------------------------------
module pmtb_walker import pmtb_pkg::*; #(
  parameter int MAX_TILE      = 64,
  parameter int PALETTE_DEPTH = 256,
  parameter int COLOR_BITS    = 32,
  parameter int AW            = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  in_item_t              in_item_i,
  output logic                  wr_en_o,
  output logic [AW-1:0]         wr_addr_o,
  output logic [COLOR_BITS-1:0] wr_data_o,
  output logic                  job_load_o,
  output byte_job_t             job_o,
  output logic [AW-1:0]         rd0_addr_o,
  output logic [AW-1:0]         rd1_addr_o
);

  localparam int TW = $clog2(MAX_TILE + 2);

  // reduce a 9-bit address sum modulo the palette depth
  function automatic logic [AW-1:0] wrap_addr(input logic [8:0] x);
    logic [8:0] r;
    r = x;
    for (int k = 5; k >= 0; k--) begin
      if (int'(r) >= (PALETTE_DEPTH << k)) begin
        r = 9'(int'(r) - (PALETTE_DEPTH << k));
      end
    end
    return AW'(r);
  endfunction

  logic [XY_W-1:0] origin_x_q, origin_y_q;
  logic [TW-1:0]   tile_width_q, rows_total_q;
  logic [1:0]      draw_format_q;
  logic            reverse_rows_q, reverse_cols_q;
  logic [7:0]      palette_base_q;
  logic [TW-1:0]   column_counter_q, row_counter_q;
  logic            tile_active_q;

  logic            start_go, byte_go;
  logic [TW-1:0]   w_new, rc_new;
  logic            packed_fmt;
  logic [TW-1:0]   col_next;
  logic            row_end, done;
  logic [XY_W-1:0] col_base, c1, sx0, sx1, sy;
  logic [7:0]      pen0, pen1;
  logic            we0, we1;

  assign start_go = accept_i && (in_item_i.action == ACT_START);
  assign byte_go  = accept_i && (in_item_i.action == ACT_DATA) && tile_active_q;

  assign wr_en_o   = accept_i && (in_item_i.action == ACT_PAL_WR);
  assign wr_addr_o = wrap_addr({1'b0, in_item_i.index_value});
  assign wr_data_o = COLOR_BITS'(in_item_i.table_value);

  always_comb begin
    // width and row count saturate at the largest tile
    w_new  = (MAX_TILE < (8 << in_item_i.size_code)) ? TW'(MAX_TILE)
                                                     : TW'(8 << in_item_i.size_code);
    rc_new = (int'(in_item_i.row_count) > MAX_TILE) ? TW'(MAX_TILE)
                                                    : TW'(in_item_i.row_count);

    packed_fmt = (draw_format_q == FMT_4PK) || (draw_format_q == FMT_4SW);
    col_next   = column_counter_q + (packed_fmt ? TW'(2) : TW'(1));
    row_end    = col_next >= tile_width_q;
    done       = row_end && ((row_counter_q + TW'(1)) >= rows_total_q);

    // swapword rotates each group of eight columns by four
    col_base = XY_W'(column_counter_q);
    if (draw_format_q == FMT_4SW) begin
      col_base = {col_base[XY_W-1:3], col_base[2:0] + 3'd4};
    end
    c1 = col_base + XY_W'(1);

    sx0 = reverse_cols_q ? (XY_W'(tile_width_q) - XY_W'(1) - col_base) : col_base;
    sx1 = reverse_cols_q ? (XY_W'(tile_width_q) - XY_W'(1) - c1) : c1;
    sy  = reverse_rows_q ? (XY_W'(rows_total_q) - XY_W'(1) - XY_W'(row_counter_q))
                         : XY_W'(row_counter_q);

    pen0 = packed_fmt ? {4'd0, in_item_i.data_byte[7:4]} : in_item_i.data_byte;
    pen1 = {4'd0, in_item_i.data_byte[3:0]};
    we0  = !((draw_format_q != FMT_8OPQ) && (pen0 == 8'd0));
    we1  = pen1 != 8'd0;

    job_o.two_pix         = packed_fmt;
    job_o.p0.pix_x        = origin_x_q + sx0;
    job_o.p0.pix_y        = origin_y_q + sy;
    job_o.p0.write_enable = we0;
    job_o.p0.last_of_item = !packed_fmt;
    job_o.p0.tile_done    = !packed_fmt && done;
    job_o.p1.pix_x        = origin_x_q + sx1;
    job_o.p1.pix_y        = origin_y_q + sy;
    job_o.p1.write_enable = we1;
    job_o.p1.last_of_item = 1'b1;
    job_o.p1.tile_done    = done;
  end

  assign job_load_o = byte_go;
  assign rd0_addr_o = wrap_addr({1'b0, palette_base_q} + {1'b0, pen0});
  assign rd1_addr_o = wrap_addr({1'b0, palette_base_q} + {1'b0, pen1});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q       <= '0;
      origin_y_q       <= '0;
      tile_width_q     <= '0;
      rows_total_q     <= '0;
      draw_format_q    <= FMT_8OPQ;
      reverse_rows_q   <= 1'b0;
      reverse_cols_q   <= 1'b0;
      palette_base_q   <= '0;
      column_counter_q <= '0;
      row_counter_q    <= '0;
      tile_active_q    <= 1'b0;
    end else if (start_go) begin
      origin_x_q       <= in_item_i.pos_x;
      origin_y_q       <= in_item_i.pos_y;
      tile_width_q     <= w_new;
      rows_total_q     <= rc_new;
      draw_format_q    <= in_item_i.format;
      reverse_rows_q   <= in_item_i.flip_rows;
      reverse_cols_q   <= in_item_i.flip_cols;
      palette_base_q   <= in_item_i.index_value;
      column_counter_q <= '0;
      row_counter_q    <= '0;
      tile_active_q    <= rc_new != '0;
    end else if (byte_go) begin
      if (row_end) begin
        column_counter_q <= '0;
        row_counter_q    <= row_counter_q + TW'(1);
        if (done) begin
          tile_active_q <= 1'b0;
        end
      end else begin
        column_counter_q <= col_next;
      end
    end
  end

endmodule

FILE: design/pmtb_out_seq.sv
// ----------------------------------------------------------------------------
// pmtb_out_seq
// holds one byte's pixels with their palette data and feeds the output register
// ----------------------------------------------------------------------------
module pmtb_out_seq import pmtb_pkg::*; #(
  parameter int COLOR_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  load_i,
  input  byte_job_t             job_i,
  input  logic [COLOR_BITS-1:0] rd0_data_i,
  input  logic [COLOR_BITS-1:0] rd1_data_i,
  input  logic                  out_stall_i,
  output logic                  free_o,
  output logic                  out_valid_o,
  output out_item_t             out_item_o
);

  logic      job_valid_q;
  byte_job_t job_q;
  logic      sel_q;
  logic      out_valid_q;
  out_item_t out_item_q;

  logic                  out_free, pull, job_last;
  pix_meta_t             pm;
  logic [COLOR_BITS-1:0] rd;
  out_item_t             out_item_d;

  assign out_free = !out_valid_q || !out_stall_i;
  assign pull     = job_valid_q && out_free;
  assign job_last = !job_q.two_pix || sel_q;
  assign free_o   = !job_valid_q || (pull && job_last);

  always_comb begin
    pm = sel_q ? job_q.p1 : job_q.p0;
    rd = sel_q ? rd1_data_i : rd0_data_i;
    out_item_d.pix_x        = pm.pix_x;
    out_item_d.pix_y        = pm.pix_y;
    out_item_d.color        = pm.write_enable ? COLOR_W'(rd) : '0;
    out_item_d.write_enable = pm.write_enable;
    out_item_d.last_of_item = pm.last_of_item;
    out_item_d.tile_done    = pm.tile_done;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_valid_q <= 1'b0;
      sel_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (load_i) begin
        job_valid_q <= 1'b1;
        sel_q       <= 1'b0;
      end else if (pull && job_last) begin
        job_valid_q <= 1'b0;
      end else if (pull) begin
        sel_q <= 1'b1;
      end
      if (pull) begin
        out_valid_q <= 1'b1;
      end else if (out_free) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      job_q <= job_i;
    end
    if (pull) begin
      out_item_q <= out_item_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

FILE: design/pmtb_checker.sv
// ----------------------------------------------------------------------------
// pmtb_checker
// port-level checks for the tile blitter, bound to the top level
// ----------------------------------------------------------------------------
`include "palette_mapped_tile_blitter_macros.svh"

module pmtb_checker import pmtb_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_item_o
);

  logic in_accept;
  logic out_held, out_take, out_first, out_clear, out_done, pair_held;

  assign in_accept = in_valid_i && !in_stall_o;
  assign out_held  = out_valid_o && out_stall_i;
  assign out_take  = out_valid_o && !out_stall_i;
  assign out_first = out_take && !out_item_o.last_of_item;
  assign out_clear = out_valid_o && !out_item_o.write_enable;
  assign out_done  = out_valid_o && out_item_o.tile_done;
  assign pair_held = out_held && !out_item_o.last_of_item;

  // stalled result holds
  `PMTB_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_held, out_valid_o && $stable(out_item_o))

  // transparent pixel carries no color
  `PMTB_ASSERT_NOW(a_clear_color, clk_i, rst_ni, out_clear, out_item_o.color == '0)

  // end of tile is always the end of a byte
  `PMTB_ASSERT_NOW(a_done_last, clk_i, rst_ni, out_done, out_item_o.last_of_item)

  // second pixel of a packed byte follows straight away
  `PMTB_ASSERT_NEXT(a_pair_follows, clk_i, rst_ni, out_first, out_valid_o && out_item_o.last_of_item)

  // no item is taken while the first pixel of a pair sits stalled
  `PMTB_ASSERT_NOW(a_pair_blocks, clk_i, rst_ni, pair_held, !in_accept)

endmodule

bind palette_mapped_tile_blitter pmtb_checker u_pmtb_checker (.*);

FILE: sim/palette_mapped_tile_blitter_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// palette_mapped_tile_blitter_test
// self-checking bench: palette fill, a directed table of corner items, then
// random tiles under three idle/stall mixes, every pixel checked in order
// ----------------------------------------------------------------------------
module palette_mapped_tile_blitter_test import pmtb_pkg::*;;

  localparam int TILE_MAX        = 64;
  localparam int ITEMS_PER_PHASE = 400;
  localparam int CYCLE_LIMIT     = 500000;
  localparam int DRAIN_CYCLES    = 10;

  // action 3 has no meaning, the block should drop it
  localparam logic [1:0] ACT_NONE = 2'd3;

  // how a directed row is checked
  typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_ONE} chk_t;

  typedef struct packed {
    in_item_t  item;
    chk_t      chk;
    out_item_t px;
  } dir_row_t;

  logic      clk_i;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_item_t  in_item_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_item_o;

  // idle and stall odds in percent
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  int n_errors   = 0;
  int cycle_cnt  = 0;
  int items_done = 0;

  // pixels still owed by the block, oldest first
  out_item_t exp_pixels [$];

  // predicted blitter state
  logic [COLOR_W-1:0] pal_mem [256];
  logic [XY_W-1:0]    t_org_x, t_org_y;
  logic [1:0]         t_fmt;
  logic               t_rev_r, t_rev_c;
  logic [7:0]         t_base;
  int                 t_w, t_rows, col_cnt, row_cnt;
  bit                 t_active;

  dir_row_t dir_tab [24];

  palette_mapped_tile_blitter u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // run guard
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // receiver back-pressure
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // one framebuffer write at the current counters
  function automatic out_item_t place_pixel(input int col, input logic [7:0] pen,
                                            input bit trans_ok, input bit last,
                                            input bit done);
    out_item_t px;
    int sx, sy;
    sx = t_rev_c ? t_w - 1 - col : col;
    sy = t_rev_r ? t_rows - 1 - row_cnt : row_cnt;
    px.pix_x        = XY_W'(int'(t_org_x) + sx);
    px.pix_y        = XY_W'(int'(t_org_y) + sy);
    px.write_enable = !(trans_ok && pen == 8'd0);
    px.color        = px.write_enable ? pal_mem[8'(t_base + pen)] : '0;
    px.last_of_item = last;
    px.tile_done    = done;
    return px;
  endfunction

  // advances the tile state for one item, returns the number of pixels drawn
  function automatic int blit_predict(input in_item_t it, output out_item_t px0,
                                      output out_item_t px1);
    int step, col;
    bit row_end, done;
    px0 = '0;
    px1 = '0;
    if (it.action == ACT_PAL_WR) begin
      pal_mem[it.index_value] = it.table_value;
      return 0;
    end
    if (it.action == ACT_START) begin
      t_w      = (8 << it.size_code) > TILE_MAX ? TILE_MAX : (8 << it.size_code);
      t_rows   = it.row_count > TILE_MAX ? TILE_MAX : int'(it.row_count);
      t_org_x  = it.pos_x;
      t_org_y  = it.pos_y;
      t_fmt    = it.format;
      t_rev_r  = it.flip_rows;
      t_rev_c  = it.flip_cols;
      t_base   = it.index_value;
      col_cnt  = 0;
      row_cnt  = 0;
      t_active = (t_rows != 0);
      return 0;
    end
    if (it.action != ACT_DATA || !t_active) return 0;

    step    = (t_fmt == FMT_8OPQ || t_fmt == FMT_8TRN) ? 1 : 2;
    row_end = (col_cnt + step >= t_w);
    done    = row_end && (row_cnt + 1 >= t_rows);
    if (step == 1) begin
      px0 = place_pixel(col_cnt, it.data_byte, t_fmt == FMT_8TRN, 1'b1, done);
    end else begin
      col = col_cnt;
      // swapword: each group of 8 columns starts at its upper half
      if (t_fmt == FMT_4SW) col = (col & ~7) | ((col + 4) & 7);
      px0 = place_pixel(col, {4'h0, it.data_byte[7:4]}, 1'b1, 1'b0, 1'b0);
      px1 = place_pixel(col + 1, {4'h0, it.data_byte[3:0]}, 1'b1, 1'b1, done);
    end
    if (row_end) begin
      col_cnt = 0;
      row_cnt++;
      if (done) t_active = 1'b0;
    end else begin
      col_cnt += step;
    end
    return step;
  endfunction

  // every field random, callers then fix what matters
  function automatic in_item_t rand_item();
    logic [95:0] raw;
    raw = {$urandom(), $urandom(), $urandom()};
    return raw[$bits(in_item_t)-1:0];
  endfunction

  function automatic in_item_t pal_item(input logic [7:0] idx, input logic [31:0] val);
    in_item_t it;
    it             = '0;
    it.action      = ACT_PAL_WR;
    it.index_value = idx;
    it.table_value = val;
    return it;
  endfunction

  function automatic in_item_t start_item(input logic [11:0] x, y, input logic [1:0] sz,
                                          input logic [6:0] rc, input logic [1:0] fmt,
                                          input logic fr, fc, input logic [7:0] base);
    in_item_t it;
    it             = '0;
    it.action      = ACT_START;
    it.pos_x       = x;
    it.pos_y       = y;
    it.size_code   = sz;
    it.row_count   = rc;
    it.format      = fmt;
    it.flip_rows   = fr;
    it.flip_cols   = fc;
    it.index_value = base;
    return it;
  endfunction

  function automatic in_item_t data_item(input logic [7:0] b);
    in_item_t it;
    it           = '0;
    it.action    = ACT_DATA;
    it.data_byte = b;
    return it;
  endfunction

  function automatic out_item_t pixel(input logic [11:0] x, y, input logic [31:0] c,
                                      input logic we, last, done);
    out_item_t px;
    px.pix_x        = x;
    px.pix_y        = y;
    px.color        = c;
    px.write_enable = we;
    px.last_of_item = last;
    px.tile_done    = done;
    return px;
  endfunction

  // offer one item, hold it through stalls, then book what it should draw
  task automatic send_item(input in_item_t it, input chk_t chk, input out_item_t typed_px);
    out_item_t px0, px1;
    int n;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);

    n = blit_predict(it, px0, px1);
    case (chk)
      CHK_MODEL: begin
        if (n > 0) exp_pixels.push_back(px0);
        if (n > 1) exp_pixels.push_back(px1);
      end
      CHK_ONE: exp_pixels.push_back(typed_px);
      default: ;
    endcase
    // dropped items do not count as work done
    if (it.action == ACT_PAL_WR || it.action == ACT_START || n > 0) items_done++;
  endtask

  // sender holds off until every owed pixel has come out
  task automatic drain_hold();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (exp_pixels.size() != 0);
  endtask

  // a start and its bytes, mostly well formed, with some noise
  task automatic random_tile();
    in_item_t it, tile;
    out_item_t no_px;
    int bpr, rows, n_bytes, cut;
    no_px = '0;

    // palette updates between tiles
    if ($urandom_range(5) == 0) begin
      it        = rand_item();
      it.action = ACT_PAL_WR;
      send_item(it, CHK_MODEL, no_px);
    end

    tile        = rand_item();
    tile.action = ACT_START;
    if ($urandom_range(29) == 0) begin
      // empty or saturated row count, kept to the smallest packed width
      tile.size_code = 2'd0;
      tile.format[1] = 1'b1;
      tile.row_count = $urandom_range(1) ? 7'd0 : 7'($urandom_range(64, 127));
    end else begin
      case ($urandom_range(19))
        0:       tile.size_code = 2'd3;
        1, 2:    tile.size_code = 2'd2;
        3, 4, 5: tile.size_code = 2'd1;
        default: tile.size_code = 2'd0;
      endcase
      bpr  = (8 << tile.size_code) / (tile.format[1] ? 2 : 1);
      rows = (48 / bpr) < 1 ? 1 : 48 / bpr;
      tile.row_count = 7'($urandom_range(1, rows));
    end
    send_item(tile, CHK_MODEL, no_px);

    bpr     = (8 << tile.size_code) / (tile.format[1] ? 2 : 1);
    rows    = tile.row_count > TILE_MAX ? TILE_MAX : int'(tile.row_count);
    n_bytes = rows * bpr;
    // now and then the tile is cut short by the next start
    cut = (n_bytes > 0 && $urandom_range(24) == 0) ? $urandom_range(n_bytes - 1) : n_bytes;

    for (int i = 0; i < cut; i++) begin
      if ($urandom_range(24) == 0) begin
        it        = rand_item();
        it.action = ACT_PAL_WR;
        send_item(it, CHK_MODEL, no_px);
      end
      it        = rand_item();
      it.action = ACT_DATA;
      // lean on transparent pens
      case ($urandom_range(9))
        0:       it.data_byte = 8'h00;
        1:       it.data_byte &= 8'h0F;
        2:       it.data_byte &= 8'hF0;
        default: ;
      endcase
      send_item(it, CHK_MODEL, no_px);
    end

    // stray bytes past the end and undefined actions
    if ($urandom_range(4) == 0) begin
      for (int i = $urandom_range(1, 2); i > 0; i--) begin
        it        = rand_item();
        it.action = $urandom_range(1) ? ACT_DATA : ACT_NONE;
        send_item(it, CHK_MODEL, no_px);
      end
    end
  endtask

  // result checker, in order against the oldest owed pixel
  always @(posedge clk_i) begin : pixel_check
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (exp_pixels.size() == 0) begin
        $error("unexpected pixel x=%0d y=%0d", out_item_o.pix_x, out_item_o.pix_y);
        n_errors++;
      end else begin
        want = exp_pixels.pop_front();
        if (out_item_o.pix_x !== want.pix_x) begin
          $error("pix_x: expected %0d, got %0d", want.pix_x, out_item_o.pix_x);
          n_errors++;
        end
        if (out_item_o.pix_y !== want.pix_y) begin
          $error("pix_y: expected %0d, got %0d", want.pix_y, out_item_o.pix_y);
          n_errors++;
        end
        if (out_item_o.color !== want.color) begin
          $error("color: expected %h, got %h", want.color, out_item_o.color);
          n_errors++;
        end
        if (out_item_o.write_enable !== want.write_enable) begin
          $error("write_enable: expected %b, got %b", want.write_enable,
                 out_item_o.write_enable);
          n_errors++;
        end
        if (out_item_o.last_of_item !== want.last_of_item) begin
          $error("last_of_item: expected %b, got %b", want.last_of_item,
                 out_item_o.last_of_item);
          n_errors++;
        end
        if (out_item_o.tile_done !== want.tile_done) begin
          $error("tile_done: expected %b, got %b", want.tile_done, out_item_o.tile_done);
          n_errors++;
        end
      end
    end
  end

  initial begin
    in_item_t  it, noop_item;
    out_item_t no_px;
    int        base_cnt;
    no_px            = '0;
    noop_item        = '0;
    noop_item.action = ACT_NONE;

    // directed corners; typed rows can be worked out by hand
    dir_tab[0]  = '{data_item(8'h5A), CHK_NONE, no_px};      // byte before any start
    dir_tab[1]  = '{noop_item, CHK_NONE, no_px};
    dir_tab[2]  = '{pal_item(8'hFF, 32'hFFFF_FFFF), CHK_NONE, no_px};
    dir_tab[3]  = '{pal_item(8'h00, 32'hA5A5_0F0F), CHK_NONE, no_px};
    // opaque 8-bit, both flips, base at the top so pen 1 wraps to entry 0
    dir_tab[4]  = '{start_item(12'd4095, 12'd4095, 2'd0, 7'd1, FMT_8OPQ, 1'b1, 1'b1, 8'hFF),
                    CHK_NONE, no_px};
    dir_tab[5]  = '{data_item(8'h01), CHK_ONE,
                    pixel(12'd6, 12'd4095, 32'hA5A5_0F0F, 1'b1, 1'b1, 1'b0)};
    dir_tab[6]  = '{data_item(8'h00), CHK_ONE,
                    pixel(12'd5, 12'd4095, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0)};
    // restart mid tile with zero rows: nothing may be drawn
    dir_tab[7]  = '{start_item(12'd0, 12'd0, 2'd3, 7'd0, FMT_8TRN, 1'b0, 1'b0, 8'h00),
                    CHK_NONE, no_px};
    dir_tab[8]  = '{data_item(8'hFF), CHK_NONE, no_px};
    // row count saturates to 64, bottom-up, so the first row lands at y+63
    dir_tab[9]  = '{start_item(12'd100, 12'd200, 2'd1, 7'd127, FMT_8TRN, 1'b1, 1'b0, 8'h00),
                    CHK_NONE, no_px};
    dir_tab[10] = '{data_item(8'h00), CHK_ONE,
                    pixel(12'd100, 12'd263, 32'h0, 1'b0, 1'b1, 1'b0)};
    dir_tab[11] = '{data_item(8'hFF), CHK_ONE,
                    pixel(12'd101, 12'd263, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0)};
    dir_tab[12] = '{pal_item(8'h7F, 32'h0000_0000), CHK_NONE, no_px};  // inside a tile
    // packed 4-bit, column mirror across the x wrap
    dir_tab[13] = '{start_item(12'd4090, 12'd10, 2'd0, 7'd1, FMT_4PK, 1'b0, 1'b1, 8'h70),
                    CHK_NONE, no_px};
    dir_tab[14] = '{data_item(8'h10), CHK_MODEL, no_px};
    dir_tab[15] = '{data_item(8'hF8), CHK_MODEL, no_px};
    dir_tab[16] = '{data_item(8'h0A), CHK_MODEL, no_px};
    dir_tab[17] = '{data_item(8'h33), CHK_MODEL, no_px};
    dir_tab[18] = '{data_item(8'h44), CHK_NONE, no_px};       // byte after tile end
    // swapword with both flips
    dir_tab[19] = '{start_item(12'd0, 12'd4095, 2'd0, 7'd1, FMT_4SW, 1'b1, 1'b1, 8'h80),
                    CHK_NONE, no_px};
    dir_tab[20] = '{data_item(8'h00), CHK_MODEL, no_px};
    dir_tab[21] = '{data_item(8'hF1), CHK_MODEL, no_px};
    dir_tab[22] = '{data_item(8'h2F), CHK_MODEL, no_px};
    dir_tab[23] = '{data_item(8'hE0), CHK_MODEL, no_px};

    t_org_x  = '0;
    t_org_y  = '0;
    t_fmt    = FMT_8OPQ;
    t_rev_r  = 1'b0;
    t_rev_c  = 1'b0;
    t_base   = '0;
    t_w      = 0;
    t_rows   = 0;
    col_cnt  = 0;
    row_cnt  = 0;
    t_active = 1'b0;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct  = 10;
    recv_stall_pct = 67;

    // load every palette entry so no pen can hit an unwritten one
    for (int a = 0; a < 256; a++) begin
      it             = rand_item();
      it.action      = ACT_PAL_WR;
      it.index_value = a[7:0];
      send_item(it, CHK_MODEL, no_px);
    end

    for (int i = 0; i < 24; i++) send_item(dir_tab[i].item, dir_tab[i].chk, dir_tab[i].px);
    drain_hold();

    // random tiles: sender light / receiver heavy, then swapped, then free running
    base_cnt = items_done;
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle_pct  = 10;
          recv_stall_pct = 67;
        end
        1: begin
          send_idle_pct  = 67;
          recv_stall_pct = 10;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
      endcase
      while (items_done < base_cnt + (ph + 1) * ITEMS_PER_PHASE) random_tile();
      drain_hold();
    end

    // catch anything extra the block still pushes out
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (n_errors == 0 && exp_pixels.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
